FILE: rtl/core/swmm_pkg.sv
// ----------------------------------------------------------------------------
// swmm_pkg: shared types and constants of the sliding window min/max core
// Default sizes, configuration width and the command/status bundles that
// join the controller and the datapath.
// ----------------------------------------------------------------------------
package swmm_pkg;

	// default sizes
	localparam int WINDOW_MAX_DEF = 1024;
	localparam int DATA_WIDTH_DEF = 32;

	// window size register width
	localparam int CFG_WIDTH = 11;

	// controller to datapath commands
	typedef struct packed {
		logic load;       // take the input item, clear on first
		logic pop_front;  // drop expired front entries that qualify
		logic pop_back;   // drop dominated back entries that qualify
		logic push;       // append sample at the tail, advance position
		logic rd_back;    // memory read address: back entry, else front
		logic out_load;   // capture both front values into the output register
	} swmm_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic front_pop;  // some deque front has expired
		logic back_pop;   // some deque back is dominated by the sample
		logic emit;       // window is full, item gives a result
	} swmm_sts_t;

endpackage

FILE: rtl/core/swmm_in_if.sv
// ----------------------------------------------------------------------------
// swmm_in_if: input channel of the sliding window min/max core
// Valid/ready channel carrying one sample and the start-of-sequence flag.
// ----------------------------------------------------------------------------
interface swmm_in_if #(
	parameter int DATA_WIDTH = 32
);
	logic                  valid;
	logic                  ready;
	logic [DATA_WIDTH-1:0] sample;
	logic                  first;

	modport source (output valid, output sample, output first, input ready);
	modport sink (input valid, input sample, input first, output ready);
endinterface

FILE: rtl/core/swmm_out_if.sv
// ----------------------------------------------------------------------------
// swmm_out_if: result channel of the sliding window min/max core
// Valid/ready channel carrying the window minimum and maximum.
// ----------------------------------------------------------------------------
interface swmm_out_if #(
	parameter int DATA_WIDTH = 32
);
	logic                  valid;
	logic                  ready;
	logic [DATA_WIDTH-1:0] window_min;
	logic [DATA_WIDTH-1:0] window_max;

	modport source (output valid, output window_min, output window_max, input ready);
	modport sink (input valid, input window_min, input window_max, output ready);
endinterface

FILE: rtl/core/swmm_deque.sv
// ----------------------------------------------------------------------------
// swmm_deque: one monotonic deque of (value, position)
// Ring buffer in a single-port-read memory with registered read data.
// IS_MAX selects the decreasing (maximum) or increasing (minimum) order.
// ----------------------------------------------------------------------------
module swmm_deque #(
	parameter int WINDOW_MAX = 1024,
	parameter int DATA_WIDTH = 32,
	parameter bit IS_MAX     = 1'b0,
	localparam int PW        = $clog2(2 * WINDOW_MAX)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  clear,
	input  logic                  pop_front_en,
	input  logic                  pop_back_en,
	input  logic                  push_en,
	input  logic                  rd_back,
	input  logic [DATA_WIDTH-1:0] sample,
	input  logic [PW-1:0]         position,
	input  logic [PW-1:0]         k,
	output logic                  front_pop,
	output logic                  back_pop,
	output logic [DATA_WIDTH-1:0] rd_val
);
	localparam int AW  = $clog2(WINDOW_MAX);
	localparam int PWX = PW + 1;
	localparam int EW  = DATA_WIDTH + PW;
	localparam logic [AW-1:0]  IDX_LAST = AW'(WINDOW_MAX - 1);
	localparam logic [PW-1:0]  CNT_FULL = PW'(WINDOW_MAX);
	localparam logic [PWX-1:0] POS_MOD  = PWX'(2 * WINDOW_MAX);

	logic [EW-1:0]   mem [WINDOW_MAX];
	logic [EW-1:0]   rd_q;
	logic [AW-1:0]   head_q;
	logic [AW-1:0]   tail_q;
	logic [PW-1:0]   count_q;
	logic [AW-1:0]   back_idx;
	logic [AW-1:0]   head_nxt;
	logic [AW-1:0]   tail_nxt;
	logic [AW-1:0]   rd_addr;
	logic [PW-1:0]   rd_pos;
	logic [PWX-1:0]  diff;
	logic [PWX-1:0]  diff_wrap;
	logic [PW-1:0]   age;
	logic            push_go;

	// ring index arithmetic
	assign back_idx = (tail_q == '0) ? IDX_LAST : tail_q - AW'(1);
	assign head_nxt = (head_q == IDX_LAST) ? '0 : head_q + AW'(1);
	assign tail_nxt = (tail_q == IDX_LAST) ? '0 : tail_q + AW'(1);
	assign rd_addr  = rd_back ? back_idx : head_q;

	// fields of the entry read last cycle
	assign rd_val = rd_q[DATA_WIDTH-1:0];
	assign rd_pos = rd_q[EW-1:DATA_WIDTH];

	// age of the read entry, modulo the position range
	assign diff      = {1'b0, position} - {1'b0, rd_pos};
	assign diff_wrap = diff + POS_MOD;
	assign age       = (position >= rd_pos) ? diff[PW-1:0] : diff_wrap[PW-1:0];

	// pop conditions
	assign front_pop = (count_q != '0) && (age >= k);
	assign back_pop  = (count_q != '0) &&
		(IS_MAX ? ($signed(sample) > $signed(rd_val)) : ($signed(sample) < $signed(rd_val)));
	assign push_go   = push_en && (count_q < CNT_FULL);

	// pointer and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else if (clear) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else if (pop_front_en && front_pop) begin
			head_q  <= head_nxt;
			count_q <= count_q - PW'(1);
		end else if (pop_back_en && back_pop) begin
			tail_q  <= back_idx;
			count_q <= count_q - PW'(1);
		end else if (push_go) begin
			tail_q  <= tail_nxt;
			count_q <= count_q + PW'(1);
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push_go) begin
			mem[tail_q] <= {position, sample};
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rd_q <= mem[rd_addr];
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_FULL)
		else $error("deque fill count above capacity");

	a_empty_ptrs: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) |-> (head_q == tail_q))
		else $error("empty deque with head and tail apart");

	a_push_fills: assert property (@(posedge clk) disable iff (!arst_n)
		push_go && !clear |=> (count_q != '0))
		else $error("deque empty right after a push");

endmodule

FILE: rtl/core/swmm_dp.sv
// ----------------------------------------------------------------------------
// swmm_dp: datapath of the sliding window min/max core
// Window size register, item latch, position and fill counters, the two
// deques and the output data register.
// ----------------------------------------------------------------------------
module swmm_dp #(
	parameter int WINDOW_MAX = 1024,
	parameter int DATA_WIDTH = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [swmm_pkg::CFG_WIDTH-1:0] cfg_wdata,
	input  logic [DATA_WIDTH-1:0]          sample,
	input  logic                           first,
	input  swmm_pkg::swmm_cmd_t            cmd,
	output swmm_pkg::swmm_sts_t            sts,
	output logic [DATA_WIDTH-1:0]          window_min,
	output logic [DATA_WIDTH-1:0]          window_max
);
	import swmm_pkg::*;

	localparam int PW = $clog2(2 * WINDOW_MAX);
	localparam logic [PW-1:0] CNT_FULL = PW'(WINDOW_MAX);
	localparam logic [PW-1:0] POS_LAST = PW'(2 * WINDOW_MAX - 1);
	localparam logic [31:0]   WMAX32   = 32'(WINDOW_MAX);

	logic [CFG_WIDTH-1:0]  window_size_q;
	logic [DATA_WIDTH-1:0] sample_q;
	logic [PW-1:0]         k_q;
	logic [PW-1:0]         position_q;
	logic [PW-1:0]         seen_q;
	logic [DATA_WIDTH-1:0] win_min_q;
	logic [DATA_WIDTH-1:0] win_max_q;
	logic [31:0]           ws_ext;
	logic [31:0]           k_full;
	logic                  clear;
	logic                  min_front_pop;
	logic                  max_front_pop;
	logic                  min_back_pop;
	logic                  max_back_pop;
	logic [DATA_WIDTH-1:0] min_rd_val;
	logic [DATA_WIDTH-1:0] max_rd_val;

	// effective window size: zero reads as one, clamp to capacity
	assign ws_ext = 32'(window_size_q);
	assign k_full = (ws_ext == '0) ? 32'd1 : ((ws_ext > WMAX32) ? WMAX32 : ws_ext);

	assign clear = cmd.load && first;

	// window size register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_size_q <= CFG_WIDTH'(1);
		end else if (cfg_we) begin
			window_size_q <= cfg_wdata;
		end
	end

	// item latch
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			sample_q <= sample;
			k_q      <= k_full[PW-1:0];
		end
	end

	// position and samples seen since sequence start
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			position_q <= '0;
			seen_q     <= '0;
		end else if (clear) begin
			position_q <= '0;
			seen_q     <= '0;
		end else if (cmd.push) begin
			position_q <= (position_q == POS_LAST) ? '0 : position_q + PW'(1);
			if (seen_q < CNT_FULL) begin
				seen_q <= seen_q + PW'(1);
			end
		end
	end

	// increasing deque, front is the minimum
	swmm_deque #(
		.WINDOW_MAX (WINDOW_MAX),
		.DATA_WIDTH (DATA_WIDTH),
		.IS_MAX     (1'b0)
	) u_min_dq (
		.clk          (clk),
		.arst_n       (arst_n),
		.clear        (clear),
		.pop_front_en (cmd.pop_front),
		.pop_back_en  (cmd.pop_back),
		.push_en      (cmd.push),
		.rd_back      (cmd.rd_back),
		.sample       (sample_q),
		.position     (position_q),
		.k            (k_q),
		.front_pop    (min_front_pop),
		.back_pop     (min_back_pop),
		.rd_val       (min_rd_val)
	);

	// decreasing deque, front is the maximum
	swmm_deque #(
		.WINDOW_MAX (WINDOW_MAX),
		.DATA_WIDTH (DATA_WIDTH),
		.IS_MAX     (1'b1)
	) u_max_dq (
		.clk          (clk),
		.arst_n       (arst_n),
		.clear        (clear),
		.pop_front_en (cmd.pop_front),
		.pop_back_en  (cmd.pop_back),
		.push_en      (cmd.push),
		.rd_back      (cmd.rd_back),
		.sample       (sample_q),
		.position     (position_q),
		.k            (k_q),
		.front_pop    (max_front_pop),
		.back_pop     (max_back_pop),
		.rd_val       (max_rd_val)
	);

	// status to the controller
	assign sts.front_pop = min_front_pop || max_front_pop;
	assign sts.back_pop  = min_back_pop || max_back_pop;
	assign sts.emit      = (seen_q >= k_q);

	// output data register
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			win_min_q <= min_rd_val;
			win_max_q <= max_rd_val;
		end
	end

	assign window_min = win_min_q;
	assign window_max = win_max_q;

endmodule

FILE: rtl/core/swmm_ctrl.sv
// ----------------------------------------------------------------------------
// swmm_ctrl: controller of the sliding window min/max core
// Sequences one item through front expiry, back pops, push and front read,
// and owns the input ready and output valid handshake.
// ----------------------------------------------------------------------------
module swmm_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	input  swmm_pkg::swmm_sts_t sts,
	output swmm_pkg::swmm_cmd_t cmd
);
	import swmm_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_FRONT_RD,
		S_FRONT_EV,
		S_BACK_RD,
		S_BACK_EV,
		S_PUSH,
		S_HEAD_RD,
		S_RESULT
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	// commands decoded from state
	always_comb begin
		cmd = '0;
		case (state_q)
			S_IDLE:     cmd.load      = in_valid;
			S_FRONT_RD: cmd.rd_back   = 1'b0;
			S_FRONT_EV: cmd.pop_front = 1'b1;
			S_BACK_RD:  cmd.rd_back   = 1'b1;
			S_BACK_EV: begin
				cmd.rd_back  = 1'b1;
				cmd.pop_back = 1'b1;
			end
			S_PUSH:     cmd.push      = 1'b1;
			S_HEAD_RD:  cmd.rd_back   = 1'b0;
			S_RESULT:   cmd.out_load  = sts.emit && out_free;
			default:    cmd = '0;
		endcase
	end

	// state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_FRONT_RD;
					end
				end
				S_FRONT_RD: state_q <= S_FRONT_EV;
				S_FRONT_EV: state_q <= sts.front_pop ? S_FRONT_RD : S_BACK_RD;
				S_BACK_RD:  state_q <= S_BACK_EV;
				S_BACK_EV:  state_q <= sts.back_pop ? S_BACK_RD : S_PUSH;
				S_PUSH:     state_q <= S_HEAD_RD;
				S_HEAD_RD:  state_q <= S_RESULT;
				S_RESULT: begin
					if (!sts.emit || out_free) begin
						state_q <= S_IDLE;
					end
				end
				default:    state_q <= S_IDLE;
			endcase
		end
	end

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("input ready while an item is in flight");

	a_load_shows_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> out_valid_q)
		else $error("loaded result not presented");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RESULT && sts.emit && out_valid_q && !out_ready) |=>
		(state_q == S_RESULT))
		else $error("result left behind while output stalled");

endmodule

FILE: rtl/core/sliding_window_min_max_core.sv
// ----------------------------------------------------------------------------
// sliding_window_min_max_core: streaming sliding window minimum and maximum
// Top level joining the controller and the datapath to the channels.
// ----------------------------------------------------------------------------
// Each input item carries a signed sample and a first flag that starts a new
// sequence. Once window_size samples have arrived since the sequence start,
// every item gives one result with the minimum and maximum of the last
// window_size samples; before that an item gives none. A window size of zero
// acts as one and sizes above WINDOW_MAX act as WINDOW_MAX; a new size takes
// effect with the next item. The block works on one item at a time: it steps
// through front expiry, back pops, push and a front read; a result loads into
// the output register once that is free, and the next item can be accepted in
// the cycle after. Each round of front expiry or back pops takes a read state
// and an evaluate state (both deques work through their rounds together), as
// each deque memory has a single registered read port. Over a stream each
// sample is pushed once and popped at most once from each deque. A finished
// result waits in the output register while the next item is accepted. No
// clearing pass is needed after reset.
module sliding_window_min_max_core #(
	parameter int WINDOW_MAX = swmm_pkg::WINDOW_MAX_DEF,
	parameter int DATA_WIDTH = swmm_pkg::DATA_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [swmm_pkg::CFG_WIDTH-1:0] cfg_wdata,
	swmm_in_if.sink                        in_ch,
	swmm_out_if.source                     out_ch
);
	import swmm_pkg::*;

	swmm_cmd_t cmd;
	swmm_sts_t sts;

	// sequencing and handshake
	swmm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// deques, counters and result data
	swmm_dp #(
		.WINDOW_MAX (WINDOW_MAX),
		.DATA_WIDTH (DATA_WIDTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.sample     (in_ch.sample),
		.first      (in_ch.first),
		.cmd        (cmd),
		.sts        (sts),
		.window_min (out_ch.window_min),
		.window_max (out_ch.window_max)
	);

endmodule

FILE: sim/sliding_window_min_max_core_tb.sv
// ----------------------------------------------------------------------------
// sliding_window_min_max_core_tb: self-checking bench for the window min/max core
// Drives signed samples with sequence-start flags through the input channel,
// keeps its own pair of monotonic deques to predict each window minimum and
// maximum, and compares every result item in order. Covers the reset window,
// zero and oversized windows, equal values, resizing mid-sequence, a full
// 1024-deep window and long random streams with random stalls on both sides.
// ----------------------------------------------------------------------------
module sliding_window_min_max_core_tb;

	import swmm_pkg::*;

	localparam int WMAX           = WINDOW_MAX_DEF;
	localparam int DW             = DATA_WIDTH_DEF;
	localparam int POS_MOD        = 2 * WMAX;
	localparam int SIDE_MIN       = 0;
	localparam int SIDE_MAX       = 1;
	// worst case: every entry of both deques popped in one item
	localparam int BUSY_CYCLES    = 4 * WMAX + 16;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int RANDOM_ITEMS   = 720;
	localparam int REPORT_MAX     = 10;

	typedef enum int {
		MODE_FULL,
		MODE_NARROW,
		MODE_RAMP,
		MODE_EDGE
	} sample_mode_t;

	typedef struct packed {
		logic [DW-1:0] lo;
		logic [DW-1:0] hi;
	} window_result_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_WIDTH-1:0] cfg_wdata;

	swmm_in_if  #(.DATA_WIDTH(DW)) in_if ();
	swmm_out_if #(.DATA_WIDTH(DW)) out_if ();

	sliding_window_min_max_core #(
		.WINDOW_MAX(WMAX),
		.DATA_WIDTH(DW)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_ch    (in_if),
		.out_ch   (out_if)
	);

	// predictor state: one deque per side, value and position per entry
	logic [DW-1:0]        dq_val  [2][WMAX];
	int                   dq_pos  [2][WMAX];
	int                   dq_head [2];
	int                   dq_tail [2];
	int                   dq_cnt  [2];
	int                   next_pos;
	int                   seen_cnt;
	logic [CFG_WIDTH-1:0] win_size;

	window_result_t window_results_q[$];

	bit            idle_on;
	bit            block_touched;
	logic [DW-1:0] ramp_val;
	bit            ramp_up;
	int            items_sent;
	int            results_seen;
	int            cfg_writes;
	int            fail_count;

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// predict the window extremes caused by one accepted item
	function automatic void predict_window(input logic [DW-1:0] smp, input logic first_flag);
		int  k;
		int  back;
		bit  pop;
		k = win_size;
		if (k == 0) k = 1;
		if (k > WMAX) k = WMAX;
		if (first_flag) begin
			for (int s = 0; s < 2; s++) begin
				dq_head[s] = 0;
				dq_tail[s] = 0;
				dq_cnt[s]  = 0;
			end
			next_pos = 0;
			seen_cnt = 0;
		end
		for (int s = 0; s < 2; s++) begin
			// expire old fronts
			while (dq_cnt[s] > 0 &&
			       ((next_pos + POS_MOD - dq_pos[s][dq_head[s]]) % POS_MOD) >= k) begin
				dq_head[s] = (dq_head[s] + 1) % WMAX;
				dq_cnt[s]--;
			end
			// drop dominated backs, equal values stay
			while (dq_cnt[s] > 0) begin
				back = (dq_tail[s] + WMAX - 1) % WMAX;
				if (s == SIDE_MAX)
					pop = $signed(smp) > $signed(dq_val[s][back]);
				else
					pop = $signed(smp) < $signed(dq_val[s][back]);
				if (!pop) break;
				dq_tail[s] = back;
				dq_cnt[s]--;
			end
			if (dq_cnt[s] < WMAX) begin
				dq_val[s][dq_tail[s]] = smp;
				dq_pos[s][dq_tail[s]] = next_pos;
				dq_tail[s] = (dq_tail[s] + 1) % WMAX;
				dq_cnt[s]++;
			end
		end
		next_pos = (next_pos + 1) % POS_MOD;
		if (seen_cnt < WMAX) seen_cnt++;
		if (seen_cnt >= k)
			window_results_q.push_back({dq_val[SIDE_MIN][dq_head[SIDE_MIN]],
			                            dq_val[SIDE_MAX][dq_head[SIDE_MAX]]});
	endfunction

	// sample generator for the random stream
	function automatic logic [DW-1:0] pick_sample(input sample_mode_t mode);
		logic [DW-1:0] edge_vals [6];
		edge_vals = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF,
		              32'h8000_0001, 32'h7FFF_FFFE};
		case (mode)
			MODE_NARROW: begin
				return $urandom_range(0, 8) - 4;
			end
			MODE_RAMP: begin
				if ($urandom_range(0, 15) == 0) ramp_up = ~ramp_up;
				if (ramp_up) ramp_val = ramp_val + $urandom_range(0, 1000);
				else ramp_val = ramp_val - $urandom_range(0, 1000);
				return ramp_val;
			end
			MODE_EDGE: begin
				return edge_vals[$urandom_range(0, 5)];
			end
			default: begin
				return $urandom;
			end
		endcase
	endfunction

	// send one item, predict on accept
	task automatic send_item(input logic [DW-1:0] smp, input logic first_flag);
		int gap;
		gap = idle_on ? $urandom_range(0, 5) : 0;
		if (gap > 0) begin
			in_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_if.valid  <= 1'b1;
		in_if.sample <= smp;
		in_if.first  <= first_flag;
		do @(posedge clk); while (in_if.ready !== 1'b1);
		predict_window(smp, first_flag);
		items_sent++;
		block_touched = 1'b1;
	endtask

	// stop sending and let every expected item come out
	task automatic drain_block();
		in_if.valid <= 1'b0;
		while (window_results_q.size() != 0) @(posedge clk);
		// the last item may give no result and still be popping entries
		if (block_touched) repeat (BUSY_CYCLES) @(posedge clk);
		block_touched = 1'b0;
	endtask

	// write the window size while the block is idle
	task automatic set_window(input logic [CFG_WIDTH-1:0] w);
		drain_block();
		cfg_we    <= 1'b1;
		cfg_wdata <= w;
		@(posedge clk);
		cfg_we    <= 1'b0;
		win_size  = w;
		cfg_writes++;
	endtask

	// default window of one, no first flag after reset, data extremes
	task automatic test_reset_window();
		send_item(32'h8000_0000, 1'b0);
		send_item(32'h7FFF_FFFF, 1'b0);
		send_item(32'h0000_0000, 1'b0);
		send_item(32'hFFFF_FFFF, 1'b0);
	endtask

	// zero window behaves as one
	task automatic test_zero_window();
		set_window('0);
		send_item(32'h0000_0005, 1'b1);
		send_item(32'hFFFF_FFF0, 1'b0);
		send_item(32'h7FFF_FFFF, 1'b0);
	endtask

	// runs of equal values in a small window
	task automatic test_equal_values();
		logic [DW-1:0] vals [8];
		vals = '{32'd5, 32'd5, 32'd5, -32'sd2, -32'sd2, 32'd7, 32'd7, 32'd5};
		set_window(11'd3);
		foreach (vals[i]) send_item(vals[i], i == 0);
	endtask

	// window shrinks and grows inside one sequence
	task automatic test_resize_mid_sequence();
		logic [DW-1:0] part_a [6];
		logic [DW-1:0] part_b [3];
		logic [DW-1:0] part_c [4];
		part_a = '{32'd10, 32'd3, 32'd8, 32'd1, 32'd9, 32'd2};
		part_b = '{32'd7, 32'd6, 32'd5};
		part_c = '{32'd4, 32'd11, 32'd0, 32'd12};
		set_window(11'd4);
		foreach (part_a[i]) send_item(part_a[i], i == 0);
		set_window(11'd2);
		foreach (part_b[i]) send_item(part_b[i], 1'b0);
		set_window(11'd5);
		foreach (part_c[i]) send_item(part_c[i], 1'b0);
	endtask

	// full depth: oversized window saturates, min deque fills, then collapses
	task automatic test_full_window();
		set_window(11'h7FF);
		for (int i = 0; i < WMAX; i++)
			send_item(32'h8000_0000 + i * 32'd4_000_000, i == 0);
		send_item(32'h8000_0000, 1'b0);
		for (int i = 0; i < 30; i++) send_item($urandom, 1'b0);
		set_window(11'd1024);
		for (int i = 0; i < 20; i++) send_item($urandom, 1'b0);
		// large shrink drops most fronts in one item
		set_window(11'd3);
		for (int i = 0; i < 20; i++) send_item(pick_sample(MODE_NARROW), 1'b0);
		set_window(11'd1025);
		for (int i = 0; i < 10; i++) send_item($urandom, 1'b0);
	endtask

	// random phases of window size, sample shape and idling
	task automatic test_random_stream();
		int           sent;
		int           phase_len;
		int           sel;
		sample_mode_t mode;
		logic         first_flag;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			sel = $urandom_range(0, 19);
			if (sel < 9) set_window(CFG_WIDTH'($urandom_range(1, 8)));
			else if (sel < 14) set_window(CFG_WIDTH'($urandom_range(9, 40)));
			else if (sel < 16) set_window(CFG_WIDTH'($urandom_range(41, 200)));
			else if (sel == 16) set_window('0);
			else drain_block();
			idle_on   = ($urandom_range(0, 3) != 0);
			mode      = sample_mode_t'($urandom_range(0, 3));
			phase_len = $urandom_range(60, 180);
			for (int i = 0; i < phase_len; i++) begin
				first_flag = (i == 0 && $urandom_range(0, 9) < 7) ||
				             ($urandom_range(0, 39) == 0);
				if ($urandom_range(0, 7) == 0)
					send_item(pick_sample(MODE_FULL), first_flag);
				else
					send_item(pick_sample(mode), first_flag);
			end
			sent += phase_len;
		end
		idle_on = 1'b1;
	endtask

	// result checker with random output stalls
	initial begin : result_checker
		window_result_t exp_res;
		int             stall;
		@(posedge arst_n);
		forever begin
			stall = idle_on ? $urandom_range(0, 5) : 0;
			if (stall > 0) begin
				out_if.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_if.ready <= 1'b1;
			do @(posedge clk); while (out_if.valid !== 1'b1);
			results_seen++;
			if (window_results_q.size() == 0) begin
				fail_count++;
				if (fail_count <= REPORT_MAX)
					$display("unexpected item: min %0d max %0d",
					         $signed(out_if.window_min), $signed(out_if.window_max));
			end else begin
				exp_res = window_results_q.pop_front();
				if (out_if.window_min !== exp_res.lo || out_if.window_max !== exp_res.hi) begin
					fail_count++;
					if (fail_count <= REPORT_MAX)
						$display("mismatch on item %0d: min exp %0d got %0d, max exp %0d got %0d",
						         results_seen, $signed(exp_res.lo), $signed(out_if.window_min),
						         $signed(exp_res.hi), $signed(out_if.window_max));
				end
			end
		end
	end

	// watchdog on cycles with no accept on either channel
	initial begin : watchdog
		int quiet;
		quiet = 0;
		@(posedge arst_n);
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("timeout after %0d quiet cycles", quiet);
		$display("status: fail");
		$finish;
	end

	// main sequence
	initial begin
		arst_n       = 1'b0;
		cfg_we       = 1'b0;
		cfg_wdata    = '0;
		in_if.valid  = 1'b0;
		in_if.sample = '0;
		in_if.first  = 1'b0;
		out_if.ready = 1'b0;
		win_size     = 11'd1;
		next_pos     = 0;
		seen_cnt     = 0;
		for (int s = 0; s < 2; s++) begin
			dq_head[s] = 0;
			dq_tail[s] = 0;
			dq_cnt[s]  = 0;
		end
		idle_on       = 1'b1;
		block_touched = 1'b0;
		ramp_val      = '0;
		ramp_up       = 1'b1;
		items_sent    = 0;
		results_seen  = 0;
		cfg_writes    = 0;
		fail_count    = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_window();
		test_zero_window();
		test_equal_values();
		test_resize_mid_sequence();
		test_full_window();
		test_random_stream();

		drain_block();
		$display("sent %0d samples, checked %0d window items, %0d window size writes",
		         items_sent, results_seen, cfg_writes);
		$display("windows from 0 to oversized, full 1024 depth, resizes within sequences");
		if (fail_count == 0) begin
			$display("status: pass");
		end else begin
			$display("%0d failing items", fail_count);
			$display("status: fail");
		end
		$finish;
	end

endmodule
